[design/cld_pkg.sv]
// ----------------------------------------------------------------------------
// cld_pkg: shared types and constants for the deque search block
// Sizes, action and status codes, word structures and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

    // Store size and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Request actions.
    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_REM_FRONT = 3'd2,
        ACT_REM_BACK  = 3'd3,
        ACT_SEARCH    = 3'd4,
        ACT_CLEAR     = 3'd5
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Request word.
    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [CNT_W-1:0]         count;
    } t_out_word;

    // Chain-wide control from the sequencing logic.
    typedef struct packed {
        logic              ins_front;
        logic              ins_back;
        logic              rem_front;
        logic [DATA_W-1:0] key;
        logic [CNT_W-1:0]  count;
    } t_chain_ctrl;

    // Per-cell control derived by the chain.
    typedef struct packed {
        logic              take_value;
        logic              take_left;
        logic              take_right;
        logic              occupied;
        logic [DATA_W-1:0] key;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[design/cld_cell.sv]
// ----------------------------------------------------------------------------
// cld_cell: one storage cell of the deque chain
// Holds one entry, shifts towards either neighbour and compares with the key.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_cell (
    input  wire logic                       i_clk,
    input  wire cld_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [cld_pkg::DATA_W-1:0] i_left,
    input  wire logic [cld_pkg::DATA_W-1:0] i_right,
    output logic      [cld_pkg::DATA_W-1:0] o_data,
    output logic                            o_match
);
    import cld_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Pick the new content: a fresh value, or a neighbour's entry.
    always_comb begin
        if (i_ctrl.take_value) begin
            n_data = i_ctrl.key;
        end else if (i_ctrl.take_left) begin
            n_data = i_left;
        end else if (i_ctrl.take_right) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Only a held entry may report a match.
    assign o_match = i_ctrl.occupied && (r_data == i_ctrl.key);
    assign o_data  = r_data;

endmodule

`default_nettype wire

[design/cld_chain.sv]
// ----------------------------------------------------------------------------
// cld_chain: row of storage cells holding the deque front to back
// Cell zero is the front; each cell hands its entry to a neighbour on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cld_chain (
    input  wire logic                                      i_clk,
    input  wire cld_pkg::t_chain_ctrl                      i_ctrl,
    output logic [cld_pkg::DEPTH-1:0][cld_pkg::DATA_W-1:0] o_data,
    output logic [cld_pkg::DEPTH-1:0]                      o_match
);
    import cld_pkg::*;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_cell_ctrl        w_ctrl;
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        logic [CNT_W-1:0]  w_pos;

        assign w_pos = CNT_W'(k);

        // Per-cell control: front insert shifts back, front removal shifts forward.
        always_comb begin
            w_ctrl.take_value = (i_ctrl.ins_front && (k == 0))
                             || (i_ctrl.ins_back && (w_pos == i_ctrl.count));
            w_ctrl.take_left  = i_ctrl.ins_front && (k != 0);
            w_ctrl.take_right = i_ctrl.rem_front;
            w_ctrl.occupied   = w_pos < i_ctrl.count;
            w_ctrl.key        = i_ctrl.key;
        end

        // Neighbour links; the ends feed back their own entry.
        if (k == 0) begin : g_first
            assign w_left = o_data[k];
        end else begin : g_mid_l
            assign w_left = o_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = o_data[k];
        end else begin : g_mid_r
            assign w_right = o_data[k+1];
        end

        cld_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (o_data[k]),
            .o_match (o_match[k])
        );
    end

endmodule

`default_nettype wire

[design/circular_list_deque_search.sv]
// ----------------------------------------------------------------------------
// circular_list_deque_search: bounded deque of signed words with search
// Inserts and removes at both ends, searches all entries, clears the store.
// ----------------------------------------------------------------------------
// Usage:
//   Request words arrive on i_in_valid / i_in_word and are held back with
//   o_in_stall. Each word carries an action and a value. Every request gives
//   exactly one result word on o_out_valid / o_out_word, stalled by
//   i_out_stall, with a status, a data value and the entry count afterwards.
//   Entries live in a row of cells, front in cell zero; a front insert or
//   removal shifts the whole row by one in the same cycle, and a search
//   compares every cell at once. The result is registered: it appears in the
//   output register the cycle after acceptance, and one request per cycle is
//   taken while the receiver keeps up.
//   When the receiver stalls, the result holds and a new request is taken
//   only once the output register is free or being emptied in that cycle.
//   Reset empties the store (count zero) and clears the output valid; cell
//   contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_deque_search (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire cld_pkg::t_in_word  i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output cld_pkg::t_out_word      o_out_word,
    input  wire logic               i_out_stall
);
    import cld_pkg::*;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic                           r_out_valid;
    t_out_word                      r_out_word;
    t_out_word                      n_out_word;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic                           w_accept;
    logic                           w_full;
    logic                           w_empty;
    logic [IDX_W-1:0]               w_tail;
    t_chain_ctrl                    w_ctrl;
    logic [DEPTH-1:0][DATA_W-1:0]   w_cell_data;
    logic [DEPTH-1:0]               w_match;

    // Handshake: the output register frees itself as it drains.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = r_count == FULL_COUNT;
    assign w_empty = r_count == '0;
    assign w_tail  = IDX_W'(r_count - CNT_W'(1));

    // Decode the request into chain control, status, data and new count.
    always_comb begin
        w_ctrl.ins_front  = 1'b0;
        w_ctrl.ins_back   = 1'b0;
        w_ctrl.rem_front  = 1'b0;
        w_ctrl.key        = i_in_word.value;
        w_ctrl.count      = r_count;
        n_count           = r_count;
        n_out_word.status = ST_OK;
        n_out_word.data   = '0;
        case (t_action'(i_in_word.action))
            ACT_INS_FRONT: begin
                if (w_full) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    w_ctrl.ins_front = w_accept;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            ACT_INS_BACK: begin
                if (w_full) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    w_ctrl.ins_back = w_accept;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            ACT_REM_FRONT: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end else begin
                    w_ctrl.rem_front = w_accept;
                    n_out_word.data  = w_cell_data[0];
                    n_count          = r_count - CNT_W'(1);
                end
            end
            ACT_REM_BACK: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end else begin
                    n_out_word.data = w_cell_data[w_tail];
                    n_count         = r_count - CNT_W'(1);
                end
            end
            ACT_SEARCH: begin
                if (|w_match) begin
                    n_out_word.data = i_in_word.value;
                end else begin
                    n_out_word.status = ST_NOTFOUND;
                end
            end
            ACT_CLEAR: begin
                if (w_empty) begin
                    n_out_word.status = ST_EMPTY;
                end
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_out_word.count = n_count;
    end

    cld_chain u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .o_data  (w_cell_data),
        .o_match (w_match)
    );

    // Count and output valid are control state; the result word is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The count never passes the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds store size");

    // An accepted back insert into a store with room grows the count by one.
    a_ins_back_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.action == ACT_INS_BACK) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("back insert did not grow the count");

    // A full status only ever goes out with a full count.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status == ST_FULL)) |-> (r_out_word.count == FULL_COUNT))
        else $error("full status with a count below the store size");

    // An empty status only ever goes out with a zero count.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status == ST_EMPTY)) |-> (r_out_word.count == '0))
        else $error("empty status with entries held");

endmodule

`default_nettype wire

[tb/tb_circular_list_deque_search.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_list_deque_search: self-checking bench for the deque search block
// Drives request words through the valid/stall handshake, predicts every
// result word from a behavioural deque kept in the bench, and compares the
// status, data and count of each result in order. Directed cases cover the
// empty and full store, both ends and the spare action codes; random traffic
// then swings the fill level up and down under three idling patterns.
// ----------------------------------------------------------------------------

module tb_circular_list_deque_search;

    import cld_pkg::*;

    // Action codes that the block must ignore.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int CYCLE_LIMIT = 200_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Deque as the bench believes it to be.
    logic signed [DATA_W-1:0] dq_words [DEPTH];
    int dq_front = 0;
    int dq_count = 0;

    // Result words still to arrive, oldest first.
    t_out_word pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int n_requests     = 0;
    int n_removed      = 0;
    int n_found        = 0;
    int n_full         = 0;
    int n_empty        = 0;
    int peak_count     = 0;

    circular_list_deque_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the deque and returns the result word it gives.
    function automatic t_out_word deque_apply(input t_in_word req);
        t_out_word res;
        logic      hit;
        res.status = ST_OK;
        res.data   = '0;
        hit        = 1'b0;
        case (req.action)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (dq_count >= DEPTH) begin
                    res.status = ST_FULL;
                    n_full++;
                end else if (req.action == ACT_INS_FRONT) begin
                    dq_front = (dq_front + DEPTH - 1) % DEPTH;
                    dq_words[dq_front] = req.value;
                    dq_count++;
                end else begin
                    dq_words[(dq_front + dq_count) % DEPTH] = req.value;
                    dq_count++;
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK: begin
                if (dq_count == 0) begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end else if (req.action == ACT_REM_FRONT) begin
                    res.data = dq_words[dq_front];
                    dq_front = (dq_front + 1) % DEPTH;
                    dq_count--;
                    n_removed++;
                end else begin
                    res.data = dq_words[(dq_front + dq_count - 1) % DEPTH];
                    dq_count--;
                    n_removed++;
                end
            end
            ACT_SEARCH: begin
                for (int k = 0; k < dq_count; k++) begin
                    if (dq_words[(dq_front + k) % DEPTH] == req.value) hit = 1'b1;
                end
                if (hit) begin
                    res.data = req.value;
                    n_found++;
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            ACT_CLEAR: begin
                if (dq_count == 0) begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end
                dq_count = 0;
                dq_front = 0;
            end
            default: ;
        endcase
        if (dq_count > peak_count) peak_count = dq_count;
        res.count = CNT_W'(dq_count);
        return res;
    endfunction

    // Offers one request word, holds it through stalls and records the
    // expected result once the block takes it.
    task automatic send_request(input logic [2:0] act, input logic signed [DATA_W-1:0] val);
        t_in_word req;
        req.action = act;
        req.value  = val;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(deque_apply(req));
        n_requests++;
    endtask

    // Receiver: random stalls, and each taken result word is checked
    // against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d data %0d count %0d",
                       o_out_word.status, o_out_word.data, o_out_word.count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_out_word.status);
                    error_count++;
                end
                if (o_out_word.data !== want.data) begin
                    $error("data mismatch: expected %0d, got %0d",
                           want.data, o_out_word.data);
                    error_count++;
                end
                if (o_out_word.count !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           want.count, o_out_word.count);
                    error_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Both removals, a search, a clear and a spare code, tried on the empty store.
    task automatic test_empty_store();
        send_request(ACT_REM_FRONT, 32'sd0);
        send_request(ACT_REM_BACK, 32'sd0);
        send_request(ACT_SEARCH, 32'sd0);
        send_request(ACT_CLEAR, 32'sd0);
        send_request(ACT_SPARE_6, 32'sh1234_5678);
    endtask

    // Extreme values at both ends, a hit, and a spare code on a live store.
    task automatic test_ends_and_extremes();
        send_request(ACT_INS_FRONT, VAL_MIN);
        send_request(ACT_INS_BACK, VAL_MAX);
        send_request(ACT_SEARCH, VAL_MAX);
        send_request(ACT_SPARE_7, VAL_MIN);
    endtask

    // Fill to the limit, refuse at both ends, take both ends, clear.
    task automatic test_full_store();
        logic signed [DATA_W-1:0] fill_val;
        for (int k = 0; k < DEPTH - 2; k++) begin
            fill_val = $signed(32'h9E37_79B9 * (k + 1));
            send_request(k[0] ? ACT_INS_FRONT : ACT_INS_BACK, fill_val);
        end
        send_request(ACT_INS_FRONT, 32'sd1);
        send_request(ACT_INS_BACK, -32'sd1);
        send_request(ACT_REM_FRONT, 32'sd0);
        send_request(ACT_REM_BACK, 32'sd0);
        send_request(ACT_CLEAR, 32'sd0);
    endtask

    // Extremes and small values in two fifths of the picks, so that searches often hit.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return VAL_MIN;
        if (roll < 10) return VAL_MAX;
        if (roll < 15) return -32'sd1;
        if (roll < 40) return $signed(32'($urandom_range(15)) - 32'd8);
        return $signed($urandom);
    endfunction

    // Random traffic whose fill level drifts up and down in bursts.
    task automatic test_random_mix(input int n_items);
        logic filling;
        int   roll;
        filling = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (k % 24 == 0) filling = $urandom_range(1);
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_request(ACT_CLEAR, pick_value());
            end else if (roll < 5) begin
                send_request($urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7, pick_value());
            end else if (roll < 25) begin
                if (dq_count > 0 && $urandom_range(99) < 60)
                    send_request(ACT_SEARCH,
                                 dq_words[(dq_front + $urandom_range(dq_count - 1)) % DEPTH]);
                else
                    send_request(ACT_SEARCH, pick_value());
            end else if ($urandom_range(99) < (filling ? 70 : 30)) begin
                send_request($urandom_range(1) ? ACT_INS_FRONT : ACT_INS_BACK, pick_value());
            end else begin
                send_request($urandom_range(1) ? ACT_REM_FRONT : ACT_REM_BACK, pick_value());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 22;
        recv_stall_pct = 75;
        test_empty_store();
        test_ends_and_extremes();
        test_full_store();
        test_random_mix(180);

        send_idle_pct  = 75;
        recv_stall_pct = 22;
        test_random_mix(180);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(180);

        // Drain, then give the last result time to settle.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests: %0d values removed, %0d searches matched,",
                 n_requests, n_removed, n_found);
        $display("%0d inserts refused when full, %0d refusals when empty, peak fill %0d.",
                 n_full, n_empty, peak_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
design/cld_pkg.sv
design/cld_cell.sv
design/cld_chain.sv
design/circular_list_deque_search.sv
tb/tb_circular_list_deque_search.sv
